// ===== rtl/iiel_pkg.sv =====
// Shared types and constants for the indexed insert/erase list.
`timescale 1ns / 1ps

package iiel_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int COUNT_W      = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_INS_RANGE   = 3'd1,
    ERR_ERASE_EMPTY = 3'd2,
    ERR_ERASE_RANGE = 3'd3,
    ERR_READ_RANGE  = 3'd4,
    ERR_FULL        = 3'd5
  } err_t;

  // Read address source for the entry memory
  typedef enum logic [2:0] {
    RA_PREV  = 3'd0,
    RA_NEXT  = 3'd1,
    RA_FIRST = 3'd2,
    RA_LAST  = 3'd3,
    RA_POS   = 3'd4
  } raddr_sel_t;

  typedef struct packed {
    logic       item_load;
    logic       idx_load_fill;
    logic       idx_load_pos;
    logic       idx_inc;
    logic       idx_dec;
    logic       fill_inc;
    logic       fill_dec;
    logic       fill_clr;
    logic       ram_re;
    raddr_sel_t raddr_sel;
    logic       ram_we;
    logic       wr_new;
    logic       cap_front;
    logic       cap_back;
    logic       cap_rd;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic err_ok;
    logic idx_eq_pos;
    logic idx_ge_fill;
    logic out_free;
  } ctl_status_t;

endpackage

// ===== rtl/iiel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module iiel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/iiel_ctrl.sv =====
// Sequencer for the list: shift loops, summary reads and result hand-off.
`timescale 1ns / 1ps

module iiel_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  iiel_pkg::ctl_status_t status,
  output iiel_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_WR,
    S_PUT,
    S_Q0,
    S_Q1,
    S_Q2,
    S_Q3,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_ins;

  assign is_ins   = (status.op == iiel_pkg::OP_INSERT);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.raddr_sel = iiel_pkg::RA_FIRST;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_Q0;
        if (status.err_ok) begin
          unique case (status.op)
            iiel_pkg::OP_INSERT: begin
              cmd.idx_load_fill = 1'b1;
              state_next        = S_RD;
            end
            iiel_pkg::OP_ERASE: begin
              cmd.idx_load_pos = 1'b1;
              cmd.fill_dec     = 1'b1;
              state_next       = S_RD;
            end
            iiel_pkg::OP_CLEAR: begin
              cmd.fill_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (is_ins && status.idx_eq_pos) begin
          state_next = S_PUT;
        end else if (!is_ins && status.idx_ge_fill) begin
          state_next = S_Q0;
        end else begin
          cmd.ram_re    = 1'b1;
          cmd.raddr_sel = is_ins ? iiel_pkg::RA_PREV : iiel_pkg::RA_NEXT;
          state_next    = S_WR;
        end
      end
      S_WR: begin
        cmd.ram_we  = 1'b1;
        cmd.idx_dec = is_ins;
        cmd.idx_inc = !is_ins;
        state_next  = S_RD;
      end
      S_PUT: begin
        cmd.ram_we   = 1'b1;
        cmd.wr_new   = 1'b1;
        cmd.fill_inc = 1'b1;
        state_next   = S_Q0;
      end
      S_Q0: begin
        cmd.ram_re    = 1'b1;
        cmd.raddr_sel = iiel_pkg::RA_FIRST;
        state_next    = S_Q1;
      end
      S_Q1: begin
        cmd.cap_front = 1'b1;
        cmd.ram_re    = 1'b1;
        cmd.raddr_sel = iiel_pkg::RA_LAST;
        state_next    = S_Q2;
      end
      S_Q2: begin
        cmd.cap_back  = 1'b1;
        cmd.ram_re    = 1'b1;
        cmd.raddr_sel = iiel_pkg::RA_POS;
        state_next    = S_Q3;
      end
      S_Q3: begin
        cmd.cap_rd = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/iiel_dpath.sv =====
// Datapath: item registers, fill count, shift index, entry memory, result register.
`timescale 1ns / 1ps

module iiel_dpath #(
  parameter int CAPACITY = iiel_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  iiel_pkg::ctl_cmd_t                  cmd,
  output iiel_pkg::ctl_status_t               status,
  input  logic [1:0]                          opcode,
  input  logic [iiel_pkg::POS_W-1:0]          position,
  input  logic signed [iiel_pkg::DATA_W-1:0]  new_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [iiel_pkg::DATA_W-1:0]  read_data,
  output logic [iiel_pkg::COUNT_W-1:0]        count,
  output logic signed [iiel_pkg::DATA_W-1:0]  front_value,
  output logic signed [iiel_pkg::DATA_W-1:0]  back_value,
  output logic                                is_empty,
  output logic [2:0]                          error_code
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > iiel_pkg::POS_W) ? CW : iiel_pkg::POS_W;
  localparam int DW = iiel_pkg::DATA_W;

  iiel_pkg::op_t              op_q;
  logic [iiel_pkg::POS_W-1:0] pos_q;
  logic [DW-1:0]              val_q;
  iiel_pkg::err_t             err_q;
  iiel_pkg::err_t             err_next;
  logic [CW-1:0]              fill;
  logic [CW-1:0]              idx;
  logic [DW-1:0]              front_q;
  logic [DW-1:0]              back_q;
  logic [DW-1:0]              rd_q;

  logic [AW-1:0]              ram_raddr;
  logic [AW-1:0]              ram_waddr;
  logic [DW-1:0]              ram_wdata;
  logic [DW-1:0]              ram_rdata;

  logic [PW-1:0]              in_pos_ext;
  logic [PW-1:0]              fill_ext;
  logic                       fill_zero;

  assign in_pos_ext = PW'(position);
  assign fill_ext   = PW'(fill);
  assign fill_zero  = (fill == '0);

  // Classify the incoming item against the current fill count
  always_comb begin
    err_next = iiel_pkg::ERR_OK;
    unique case (iiel_pkg::op_t'(opcode))
      iiel_pkg::OP_INSERT: begin
        if (in_pos_ext > fill_ext) begin
          err_next = iiel_pkg::ERR_INS_RANGE;
        end else if (fill >= CW'(CAPACITY)) begin
          err_next = iiel_pkg::ERR_FULL;
        end
      end
      iiel_pkg::OP_ERASE: begin
        if (fill_zero) begin
          err_next = iiel_pkg::ERR_ERASE_EMPTY;
        end else if (in_pos_ext >= fill_ext) begin
          err_next = iiel_pkg::ERR_ERASE_RANGE;
        end
      end
      iiel_pkg::OP_READ: begin
        if (in_pos_ext >= fill_ext) begin
          err_next = iiel_pkg::ERR_READ_RANGE;
        end
      end
      default: begin
        err_next = iiel_pkg::ERR_OK;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.raddr_sel)
      iiel_pkg::RA_PREV:  ram_raddr = AW'(idx - CW'(1));
      iiel_pkg::RA_NEXT:  ram_raddr = AW'(idx + CW'(1));
      iiel_pkg::RA_FIRST: ram_raddr = '0;
      iiel_pkg::RA_LAST:  ram_raddr = AW'(fill - CW'(1));
      iiel_pkg::RA_POS:   ram_raddr = AW'(pos_q);
      default:            ram_raddr = '0;
    endcase
  end

  assign ram_waddr = cmd.wr_new ? AW'(pos_q) : AW'(idx);
  assign ram_wdata = cmd.wr_new ? val_q : ram_rdata;

  iiel_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status.op          = op_q;
  assign status.err_ok      = (err_q == iiel_pkg::ERR_OK);
  assign status.idx_eq_pos  = (PW'(idx) == PW'(pos_q));
  assign status.idx_ge_fill = (idx >= fill);
  assign status.out_free    = !out_valid || out_ready;

  // Item, shift index, capture and output registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      op_q  <= iiel_pkg::op_t'(opcode);
      pos_q <= position;
      val_q <= new_value;
      err_q <= err_next;
    end
    if (cmd.idx_load_fill) begin
      idx <= fill;
    end else if (cmd.idx_load_pos) begin
      idx <= CW'(pos_q);
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - CW'(1);
    end
    if (cmd.cap_front) begin
      front_q <= ram_rdata;
    end
    if (cmd.cap_back) begin
      back_q <= ram_rdata;
    end
    if (cmd.cap_rd) begin
      rd_q <= ram_rdata;
    end
    if (cmd.out_load) begin
      read_data   <= (op_q == iiel_pkg::OP_READ && err_q == iiel_pkg::ERR_OK) ? rd_q : '0;
      count       <= iiel_pkg::COUNT_W'(fill);
      front_value <= fill_zero ? '0 : front_q;
      back_value  <= fill_zero ? '0 : back_q;
      is_empty    <= fill_zero;
      error_code  <= err_q;
    end
  end

  // Control state: fill count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.fill_clr) begin
        fill <= '0;
      end else if (cmd.fill_inc) begin
        fill <= fill + CW'(1);
      end else if (cmd.fill_dec) begin
        fill <= fill - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

  a_grow_only_on_good_insert: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_inc |-> (op_q == iiel_pkg::OP_INSERT && err_q == iiel_pkg::ERR_OK))
    else $error("fill grew outside a good insert");

  a_shrink_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_dec |-> !fill_zero)
    else $error("fill shrank below zero");

endmodule

// ===== rtl/indexed_insert_erase_list_core.sv =====
// Top level of the indexed insert/erase list of signed 32-bit words.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries opcode, position and new_value.
//   Output channel (out_valid/out_ready) carries one result item per input
//   item: read_data, count, front_value, back_value, is_empty, error_code.
//   Entries live in a single-port-write, single-port-read RAM of CAPACITY words.
//   An insert shifts the entries from position p to the end up by one and
//   then writes new_value at p; an erase moves the entries after p down by one.
//   Each moved entry costs one RAM read and one RAM write; after the shift loop,
//   front, back and read data are fetched one per cycle from the single read
//   port. Read, clear and refused items skip the shift loop.
//   One item is in work at a time; in_ready is high while the sequencer idles,
//   including while a finished result still waits in the output register.
//   The next item is taken the cycle after a result loads. If the receiver stalls,
//   the finished result holds and the sequencer waits with the next result until
//   the output register frees up.
//   Reset (rst, synchronous) empties the list and drops any pending result;
//   entry contents are left as they are and stale entries never reach the outputs.
module indexed_insert_erase_list_core #(
  parameter int CAPACITY = iiel_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          opcode,
  input  logic [iiel_pkg::POS_W-1:0]          position,
  input  logic signed [iiel_pkg::DATA_W-1:0]  new_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [iiel_pkg::DATA_W-1:0]  read_data,
  output logic [iiel_pkg::COUNT_W-1:0]        count,
  output logic signed [iiel_pkg::DATA_W-1:0]  front_value,
  output logic signed [iiel_pkg::DATA_W-1:0]  back_value,
  output logic                                is_empty,
  output logic [2:0]                          error_code
);

  // Command and status between the sequencer and the datapath
  iiel_pkg::ctl_cmd_t    cmd;
  iiel_pkg::ctl_status_t status;

  // Sequencer: accept, shift loop, summary reads, hand the result over
  iiel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: item registers, fill count, entry memory, output register
  iiel_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .opcode      (opcode),
    .position    (position),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .error_code  (error_code)
  );

endmodule

// ===== verif/tb_indexed_insert_erase_list_core.sv =====
// Self-checking testbench for the indexed insert/erase list core.
`timescale 1ns / 1ps

module tb_indexed_insert_erase_list_core;

  localparam int LIST_DEPTH   = iiel_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 800;
  // The limit allows for the longest shift, sender gap and receiver stall all at
  // once on every item, and still leaves ample headroom.
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_AT_ITEM = 150;
  localparam int HOLD_CYCLES  = 300;

  // One list operation as the sender offers it. drain_first holds the
  // operation back until every earlier result has come out.
  typedef struct {
    iiel_pkg::op_t                     op;
    logic [iiel_pkg::POS_W-1:0]        pos;
    logic signed [iiel_pkg::DATA_W-1:0] val;
    bit                                drain_first;
  } list_cmd_t;

  // List state and status that one result item reports.
  typedef struct {
    logic signed [iiel_pkg::DATA_W-1:0] rd;
    logic [iiel_pkg::COUNT_W-1:0]       cnt;
    logic signed [iiel_pkg::DATA_W-1:0] front;
    logic signed [iiel_pkg::DATA_W-1:0] back;
    logic                               empty;
    iiel_pkg::err_t                     err;
  } list_status_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [1:0]                         opcode = iiel_pkg::OP_CLEAR;
  logic [iiel_pkg::POS_W-1:0]         position = '0;
  logic signed [iiel_pkg::DATA_W-1:0] new_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [iiel_pkg::DATA_W-1:0] read_data;
  logic [iiel_pkg::COUNT_W-1:0]       count;
  logic signed [iiel_pkg::DATA_W-1:0] front_value;
  logic signed [iiel_pkg::DATA_W-1:0] back_value;
  logic                               is_empty;
  logic [2:0]                         error_code;

  indexed_insert_erase_list_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .position    (position),
    .new_value   (new_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .error_code  (error_code)
  );

  list_cmd_t    cmd_backlog[$];   // operations not yet offered
  list_status_t status_due[$];    // predicted results, oldest first

  // Shadow copy of the list contents and fill level.
  logic signed [iiel_pkg::DATA_W-1:0] shadow_list [LIST_DEPTH];
  int unsigned                        shadow_fill;

  int unsigned n_acc;     // items taken by the block
  int unsigned n_got;     // results taken from the block (nonblocking)
  int unsigned n_fail;
  int unsigned cyc;

  // ---------------------------------------------------------------------
  // Prediction: apply one operation to the shadow list, return the status.
  // ---------------------------------------------------------------------
  function automatic list_status_t apply_list_op(list_cmd_t c);
    list_status_t s;
    int unsigned  i;
    s.rd  = '0;
    s.err = iiel_pkg::ERR_OK;
    case (c.op)
      iiel_pkg::OP_INSERT: begin
        if (c.pos > shadow_fill) begin
          s.err = iiel_pkg::ERR_INS_RANGE;   // index beyond size wins over full
        end else if (shadow_fill >= LIST_DEPTH) begin
          s.err = iiel_pkg::ERR_FULL;
        end else begin
          for (i = shadow_fill; i > c.pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[c.pos] = c.val;
          shadow_fill++;
        end
      end
      iiel_pkg::OP_ERASE: begin
        if (shadow_fill == 0) begin
          s.err = iiel_pkg::ERR_ERASE_EMPTY; // empty wins over range
        end else if (c.pos >= shadow_fill) begin
          s.err = iiel_pkg::ERR_ERASE_RANGE;
        end else begin
          shadow_fill--;
          for (i = c.pos; i < shadow_fill; i++) shadow_list[i] = shadow_list[i+1];
        end
      end
      iiel_pkg::OP_READ: begin
        if (c.pos >= shadow_fill) s.err = iiel_pkg::ERR_READ_RANGE;
        else s.rd = shadow_list[c.pos];
      end
      default: shadow_fill = 0;
    endcase
    s.cnt   = shadow_fill[iiel_pkg::COUNT_W-1:0];
    s.empty = (shadow_fill == 0);
    s.front = s.empty ? '0 : shadow_list[0];
    s.back  = s.empty ? '0 : shadow_list[shadow_fill-1];
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation. gen_fill tracks only the list size so that most
  // positions land inside the list and the list wanders over its range.
  // ---------------------------------------------------------------------
  int unsigned gen_fill;

  task automatic queue_cmd(iiel_pkg::op_t op, int unsigned pos,
                           logic signed [iiel_pkg::DATA_W-1:0] val,
                           bit drain_first = 1'b0);
    list_cmd_t c;
    c.op          = op;
    c.pos         = pos[iiel_pkg::POS_W-1:0];
    c.val         = val;
    c.drain_first = drain_first;
    cmd_backlog.push_back(c);
    case (op)
      iiel_pkg::OP_INSERT: if (pos <= gen_fill && gen_fill < LIST_DEPTH) gen_fill++;
      iiel_pkg::OP_ERASE:  if (gen_fill > 0 && pos < gen_fill) gen_fill--;
      iiel_pkg::OP_CLEAR:  gen_fill = 0;
      default: ;
    endcase
  endtask

  function automatic logic signed [iiel_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in range; now and then anywhere from 0 to LIST_DEPTH.
  function automatic int unsigned pick_pos(iiel_pkg::op_t op);
    if ($urandom_range(0, 99) < 15) return $urandom_range(0, LIST_DEPTH);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return (op == iiel_pkg::OP_INSERT || gen_fill == 0) ? gen_fill
                                                                   : gen_fill - 1;
      default: begin
        if (op == iiel_pkg::OP_INSERT) return $urandom_range(0, gen_fill);
        if (gen_fill == 0)             return $urandom_range(0, LIST_DEPTH);
        return $urandom_range(0, gen_fill - 1);
      end
    endcase
  endfunction

  // Insert weight w_ins, erase weight w_era, the rest reads and rare clears.
  task automatic queue_mix(int unsigned w_ins, int unsigned w_era, bit drain_first);
    int unsigned   r;
    iiel_pkg::op_t op;
    r = $urandom_range(0, 99);
    if (r < w_ins)              op = iiel_pkg::OP_INSERT;
    else if (r < w_ins + w_era) op = iiel_pkg::OP_ERASE;
    else if (r < 98)            op = iiel_pkg::OP_READ;
    else                        op = iiel_pkg::OP_CLEAR;
    queue_cmd(op, pick_pos(op), pick_value(), drain_first);
  endtask

  task automatic build_stimulus();
    int unsigned n;
    int unsigned run;
    int unsigned mode;
    int unsigned round;
    int unsigned k;
    bit          drain;

    gen_fill = 0;
    // Directed opening: the error paths of an empty list first.
    queue_cmd(iiel_pkg::OP_READ,   0,  '0);            // read out of range on empty
    queue_cmd(iiel_pkg::OP_ERASE,  0,  '0);            // erase on empty list
    queue_cmd(iiel_pkg::OP_ERASE,  64, '0);            // empty check precedes range
    queue_cmd(iiel_pkg::OP_INSERT, 1,  32'sh12345678); // insert beyond size
    queue_cmd(iiel_pkg::OP_CLEAR,  0,  '0);            // clear an empty list
    queue_cmd(iiel_pkg::OP_INSERT, 0,  32'sh7FFFFFFF); // push front into empty
    queue_cmd(iiel_pkg::OP_INSERT, 1,  32'sh80000000); // push back at size
    queue_cmd(iiel_pkg::OP_INSERT, 1,  32'sh55555555); // insert in the middle
    queue_cmd(iiel_pkg::OP_INSERT, 0,  32'shAAAAAAAA); // push front, shift all
    queue_cmd(iiel_pkg::OP_INSERT, 3,  -32'sd1);
    queue_cmd(iiel_pkg::OP_INSERT, 6,  32'sh0F0F0F0F); // one past size
    queue_cmd(iiel_pkg::OP_READ,   0,  32'sh77777777); // value ignored on read
    queue_cmd(iiel_pkg::OP_READ,   4,  '0);            // read back entry
    queue_cmd(iiel_pkg::OP_READ,   2,  '0);
    queue_cmd(iiel_pkg::OP_READ,   5,  '0);            // read at size
    queue_cmd(iiel_pkg::OP_READ,   64, '0);            // index at capacity
    queue_cmd(iiel_pkg::OP_ERASE,  5,  '0);            // erase at size
    queue_cmd(iiel_pkg::OP_ERASE,  64, '0);
    queue_cmd(iiel_pkg::OP_ERASE,  2,  '0);            // erase from middle
    queue_cmd(iiel_pkg::OP_ERASE,  0,  '0);            // pop front
    queue_cmd(iiel_pkg::OP_ERASE,  2,  '0);            // pop back
    queue_cmd(iiel_pkg::OP_CLEAR,  0,  -32'sd1);       // clear non-empty list
    queue_cmd(iiel_pkg::OP_READ,   0,  '0);
    queue_cmd(iiel_pkg::OP_INSERT, 64, 32'sh01020304); // index at capacity on empty list
    queue_cmd(iiel_pkg::OP_INSERT, 0,  '0);

    // Random rounds, each with its own bias.
    n     = 0;
    round = 0;
    while (n < RANDOM_ITEMS) begin
      mode  = $urandom_range(0, 9);
      drain = (round == 3) || ($urandom_range(0, 9) == 0);
      round++;
      if (mode == 8) begin
        // Fill to capacity, poke the full list, then erase one entry and refill it.
        k = 0;
        while (gen_fill < LIST_DEPTH) begin
          queue_cmd(iiel_pkg::OP_INSERT, $urandom_range(0, gen_fill), pick_value(),
                    drain && k == 0);
          k++;
        end
        queue_cmd(iiel_pkg::OP_INSERT, LIST_DEPTH, pick_value(), drain && k == 0);
        queue_cmd(iiel_pkg::OP_INSERT, $urandom_range(0, LIST_DEPTH - 1), pick_value());
        queue_cmd(iiel_pkg::OP_READ, LIST_DEPTH - 1, '0);
        queue_cmd(iiel_pkg::OP_READ, LIST_DEPTH, '0);
        queue_cmd(iiel_pkg::OP_ERASE, LIST_DEPTH, '0);
        queue_cmd(iiel_pkg::OP_ERASE, $urandom_range(0, LIST_DEPTH - 1), '0);
        queue_cmd(iiel_pkg::OP_INSERT, LIST_DEPTH - 1, pick_value());
        n += k + 7;
      end else begin
        run = $urandom_range(10, 40);
        for (k = 0; k < run; k++) begin
          case (mode)
            0, 1, 2: queue_mix(75, 10, drain && k == 0);
            3, 4, 5: queue_mix(15, 70, drain && k == 0);
            9: begin
              if (k == 0) begin
                queue_cmd(iiel_pkg::OP_CLEAR, pick_pos(iiel_pkg::OP_CLEAR), pick_value(),
                          drain);
              end else begin
                queue_mix(40, 30, 1'b0);
              end
            end
            default: queue_mix(35, 30, drain && k == 0);
          endcase
        end
        n += run;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset and the end of the run.
  // ---------------------------------------------------------------------
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    build_stimulus();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the backlog to be offered and taken, then for every result.
    // Sample between edges so that every update of the edge has settled.
    while (cmd_backlog.size() != 0 || in_valid) @(negedge clk);
    while (n_got != n_acc) @(negedge clk);
    // Give a stray extra result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (status_due.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, status_due.size());
      n_fail++;
    end
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: end the run once the cycle count reaches LIMIT_CYCLES.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT_CYCLES) begin
      $display("%0t: watchdog expired after %0d cycles", $time, cyc);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver: offer backlog items with random gaps. Predict on acceptance.
  // ---------------------------------------------------------------------
  int unsigned send_gap;
  bit          send_next_valid;
  bit          send_slot_free;
  list_cmd_t   send_cmd;
  list_cmd_t   send_head;

  // Short gaps mostly, a few long ones, none during a burst window.
  function automatic int unsigned pick_send_gap();
    int unsigned r;
    if (n_acc >= 300 && n_acc < 400) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      send_gap    = 0;
      shadow_fill = 0;
      n_acc       = 0;
    end else begin
      send_slot_free  = !in_valid || in_ready;
      send_next_valid = in_valid;
      // Take the item the block accepts at this edge and predict its result.
      if (in_valid && in_ready) begin
        status_due.push_back(apply_list_op(send_cmd));
        n_acc++;
      end
      if (send_slot_free) begin
        send_next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() != 0) begin
          send_head = cmd_backlog[0];
          // A drain-marked item waits until every result is back.
          if (!send_head.drain_first || n_got == n_acc) begin
            send_cmd = cmd_backlog.pop_front();
            opcode    <= send_cmd.op;
            position  <= send_cmd.pos;
            new_value <= send_cmd.val;
            send_next_valid = 1'b1;
            send_gap = pick_send_gap();
          end
        end
      end
      in_valid <= send_next_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: stall the result side at random, check each accepted result.
  // ---------------------------------------------------------------------
  int unsigned  recv_stall;
  int unsigned  recv_hold;
  bit           recv_hold_done;
  bit           recv_next_ready;
  list_status_t recv_want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready      <= 1'b0;
      n_got          <= 0;
      recv_stall     = 0;
      recv_hold      = 0;
      recv_hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_got <= n_got + 1;
        if (status_due.size() == 0) begin
          $display("%0t: unexpected result: rd=%0d cnt=%0d front=%0d back=%0d empty=%0b err=%0d",
                   $time, read_data, count, front_value, back_value, is_empty, error_code);
          n_fail++;
        end else begin
          recv_want = status_due.pop_front();
          if (read_data !== recv_want.rd) begin
            $display("%0t: read_data expected %0d, got %0d", $time, recv_want.rd, read_data);
            n_fail++;
          end
          if (count !== recv_want.cnt) begin
            $display("%0t: count expected %0d, got %0d", $time, recv_want.cnt, count);
            n_fail++;
          end
          if (front_value !== recv_want.front) begin
            $display("%0t: front_value expected %0d, got %0d",
                     $time, recv_want.front, front_value);
            n_fail++;
          end
          if (back_value !== recv_want.back) begin
            $display("%0t: back_value expected %0d, got %0d",
                     $time, recv_want.back, back_value);
            n_fail++;
          end
          if (is_empty !== recv_want.empty) begin
            $display("%0t: is_empty expected %0b, got %0b", $time, recv_want.empty, is_empty);
            n_fail++;
          end
          if (error_code !== recv_want.err) begin
            $display("%0t: error_code expected %0d, got %0d",
                     $time, recv_want.err, error_code);
            n_fail++;
          end
        end
      end

      // One long hold-off lets the output register fill and the block stall
      // its input while the sender keeps offering items.
      if (recv_hold > 0) begin
        recv_hold--;
        recv_next_ready = 1'b0;
      end else if (!recv_hold_done && n_acc >= HOLD_AT_ITEM) begin
        recv_hold_done  = 1'b1;
        recv_hold       = HOLD_CYCLES;
        recv_next_ready = 1'b0;
      end else if (n_got >= 500 && n_got < 600) begin
        recv_next_ready = 1'b1;   // stretch with the receiver always ready
      end else if (recv_stall > 0) begin
        recv_stall--;
        recv_next_ready = 1'b0;
      end else if ($urandom_range(0, 99) < 65) begin
        recv_next_ready = 1'b1;
      end else begin
        recv_stall      = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 3)
                                                       : $urandom_range(10, 40);
        recv_next_ready = 1'b0;
      end
      out_ready <= recv_next_ready;
    end
  end

endmodule

// ===== indexed_insert_erase_list_core.f =====
rtl/iiel_pkg.sv
rtl/iiel_ram.sv
rtl/iiel_ctrl.sv
rtl/iiel_dpath.sv
rtl/indexed_insert_erase_list_core.sv
verif/tb_indexed_insert_erase_list_core.sv
